/* hw/rtl/csem_pkg.sv */
package csem_pkg;

    localparam int CountBits = 16;
    localparam int IdPortBits = 8;
    localparam int AmountBits = 8;
    localparam int WaitingBits = 5;

    // operation codes (slave tuser)
    localparam logic OP_WAIT   = 1'b0;
    localparam logic OP_SIGNAL = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_PROCEED = 2'd0;
    localparam logic [1:0] STAT_QUEUED  = 2'd1;
    localparam logic [1:0] STAT_DROPPED = 2'd2;

    typedef logic signed [CountBits-1:0] t_count;
    typedef logic signed [CountBits+1:0] t_count_wide;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    function automatic t_count sat_count(input t_count_wide v);
        t_count_wide hi;
        t_count_wide lo;
        hi = t_count_wide'(32767);
        lo = -t_count_wide'(32768);
        if (v > hi) begin
            return t_count'(hi);
        end else if (v < lo) begin
            return t_count'(lo);
        end
        return t_count'(v);
    endfunction

endpackage

/* hw/rtl/csem_queue.sv */
module csem_queue #(
    parameter int DEPTH = 16,
    parameter int ID_BITS = 8,
    parameter int PTR_BITS = $clog2(DEPTH),
    parameter int USED_BITS = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  csem_pkg::t_q_ctrl    i_ctrl,
    input  logic [ID_BITS-1:0]   i_wr_id,
    output logic [ID_BITS-1:0]   o_rd_id,
    output logic [USED_BITS-1:0] o_used,
    output csem_pkg::t_q_flags   o_flags
);

    logic [ID_BITS-1:0]   r_mem [DEPTH];
    logic [ID_BITS-1:0]   r_rd_id;
    logic [PTR_BITS-1:0]  r_head;
    logic [PTR_BITS-1:0]  r_tail;
    logic [USED_BITS-1:0] r_used;
    logic [PTR_BITS-1:0]  n_head;
    logic [PTR_BITS-1:0]  n_tail;
    logic [USED_BITS-1:0] n_used;

    localparam logic [PTR_BITS-1:0]  LastPtr = PTR_BITS'(DEPTH - 1);
    localparam logic [USED_BITS-1:0] FullCount = USED_BITS'(DEPTH);

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_used = r_used;
        if (i_ctrl.push) begin
            n_tail = (r_tail == LastPtr) ? '0 : r_tail + 1'b1;
            n_used = n_used + 1'b1;
        end
        if (i_ctrl.pop) begin
            n_head = (r_head == LastPtr) ? '0 : r_head + 1'b1;
            n_used = n_used - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_used <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_used <= n_used;
        end
    end

    // one write port at the tail, one registered read port at the head
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail] <= i_wr_id;
        end
        if (i_ctrl.pop) begin
            r_rd_id <= r_mem[r_head];
        end
    end

    assign o_rd_id = r_rd_id;
    assign o_used = r_used;
    assign o_flags.full = (r_used == FullCount);
    assign o_flags.empty = (r_used == '0);

endmodule

/* hw/rtl/counting_semaphore_wait_queue_top.sv */
// Channel  | Direction | tdata (low bit up)                         | tuser
// s_axis   | in        | thread_id[7:0], amount[15:8]               | operation[0]
// m_axis   | out       | woken_thread[7:0], count[23:8],            | status[1:0],
//          |           | waiting[28:24], zero[31:29]                | woken_valid[2]
// cfg      | in        | i_cfg_wdata = initial_count (also loads the counter)
//
// A wait, or a signal that wakes nobody, is registered directly; a signal that wakes
// a thread waits in ST_POP for the head entry read from the queue memory.
// One item is in flight at a time; the next is taken once its result is registered.
// Reset (synchronous, active low) clears the counter to 0 and empties the queue.
// A stalled result holds in the output register; input is taken while it drains.
module counting_semaphore_wait_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // thread_id[7:0], amount[15:8]
    input  logic [0:0]  i_s_axis_tuser,   // operation[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // woken_thread[7:0], count[23:8], waiting[28:24]
    output logic [2:0]  o_m_axis_tuser,   // status[1:0], woken_valid[2]
    input  logic        i_cfg_wen,
    input  logic [15:0] i_cfg_wdata
);

    localparam int UsedBits = $clog2(QUEUE_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    logic r_state;
    logic n_state;

    csem_pkg::t_count r_counter;
    csem_pkg::t_count n_counter;

    logic                              r_out_valid;
    logic [1:0]                        r_out_status;
    logic                              r_out_wvalid;
    logic [csem_pkg::IdPortBits-1:0]   r_out_wthread;
    csem_pkg::t_count                  r_out_count;
    logic [csem_pkg::WaitingBits-1:0]  r_out_waiting;

    csem_pkg::t_q_ctrl                 w_qctrl;
    csem_pkg::t_q_flags                w_qflags;
    logic [THREAD_ID_BITS-1:0]         w_rd_id;
    logic [UsedBits-1:0]               w_used;
    logic [UsedBits-1:0]               w_used_next;
    logic [31:0]                       w_used_ext;
    logic [31:0]                       w_tid_ext;
    logic [31:0]                       w_rd_ext;

    logic                              w_out_free;
    logic                              w_fire;
    logic                              w_op;
    logic [csem_pkg::IdPortBits-1:0]   w_tid;
    logic [csem_pkg::AmountBits-1:0]   w_amt;
    csem_pkg::t_count_wide             w_cnt_wide;
    csem_pkg::t_count_wide             w_amt_wide;
    csem_pkg::t_count                  w_cnt_after;
    logic                              w_block;
    logic [1:0]                        w_status;

    assign w_op  = i_s_axis_tuser[0];
    assign w_tid = i_s_axis_tdata[7:0];
    assign w_amt = i_s_axis_tdata[15:8];

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_fire = i_s_axis_tvalid && o_s_axis_tready;

    assign w_cnt_wide = csem_pkg::t_count_wide'(r_counter);
    assign w_amt_wide = csem_pkg::t_count_wide'({10'd0, w_amt});

    always_comb begin
        w_cnt_after = r_counter;
        w_block = 1'b0;
        w_status = csem_pkg::STAT_PROCEED;
        w_qctrl = '0;
        if (w_op == csem_pkg::OP_WAIT) begin
            // skip the subtraction once the count has gone negative
            if (!r_counter[csem_pkg::CountBits-1]) begin
                w_cnt_after = csem_pkg::sat_count(w_cnt_wide - w_amt_wide);
                w_block = w_cnt_after[csem_pkg::CountBits-1];
            end else begin
                w_block = 1'b1;
            end
            if (w_block) begin
                if (w_qflags.full) begin
                    w_status = csem_pkg::STAT_DROPPED;
                end else begin
                    w_status = csem_pkg::STAT_QUEUED;
                    w_qctrl.push = w_fire;
                end
            end
        end else begin
            w_cnt_after = csem_pkg::sat_count(w_cnt_wide + w_amt_wide);
            w_qctrl.pop = w_fire && !w_cnt_after[csem_pkg::CountBits-1] && !w_qflags.empty;
        end
    end

    assign w_used_next = w_qctrl.push ? w_used + 1'b1 :
                         w_qctrl.pop  ? w_used - 1'b1 : w_used;
    assign w_used_ext = 32'(w_used_next);
    assign w_tid_ext = 32'(w_tid);
    assign w_rd_ext = 32'(w_rd_id);

    csem_queue #(
        .DEPTH   (QUEUE_DEPTH),
        .ID_BITS (THREAD_ID_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_qctrl),
        .i_wr_id (w_tid_ext[THREAD_ID_BITS-1:0]),
        .o_rd_id (w_rd_id),
        .o_used  (w_used),
        .o_flags (w_qflags)
    );

    always_comb begin
        n_counter = r_counter;
        if (i_cfg_wen) begin
            n_counter = csem_pkg::t_count'(i_cfg_wdata);
        end else if (w_fire) begin
            n_counter = w_cnt_after;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_qctrl.pop) begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_counter <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_counter <= n_counter;
            if (r_state == ST_POP) begin
                r_out_valid <= 1'b1;
            end else if (w_fire) begin
                // a wake waits in ST_POP for the head entry to be read
                r_out_valid <= !w_qctrl.pop;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_POP) begin
            r_out_wthread <= w_rd_ext[csem_pkg::IdPortBits-1:0];
        end else if (w_fire) begin
            r_out_status <= w_status;
            r_out_wvalid <= w_qctrl.pop;
            r_out_wthread <= '0;
            r_out_count <= w_cnt_after;
            r_out_waiting <= w_used_ext[csem_pkg::WaitingBits-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = {3'd0, r_out_waiting, r_out_count, r_out_wthread};
    assign o_m_axis_tuser = {r_out_wvalid, r_out_status};

endmodule

/* hw/rtl/csem_checker.sv */
module csem_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser
);

    localparam logic [31:0] DepthExt = 32'(QUEUE_DEPTH);

    // a wake only comes from a signal, which always proceeds
    a_wake_proceeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[2] |-> o_m_axis_tuser[1:0] == csem_pkg::STAT_PROCEED)
        else $error("wake reported with a blocked status");

    a_no_wake_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[2] |-> o_m_axis_tdata[7:0] == '0)
        else $error("woken thread id set without a wake");

    // a dropped id means the queue was full
    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1:0] == csem_pkg::STAT_DROPPED
        |-> o_m_axis_tdata[28:24] == DepthExt[4:0])
        else $error("id dropped while the queue had room");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser[1:0] != 2'd3 && o_m_axis_tdata[31:29] == '0)
        else $error("undefined status code or padding bits set");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind counting_semaphore_wait_queue_top csem_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_csem_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
